/* sv/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants for the loopback serial register block.
// ----------------------------------------------------------------------------
package alr_pkg;

  // Register select of one bus access.
  typedef enum logic [1:0] {
    ADDR_DATA    = 2'd0,
    ADDR_STATUS  = 2'd1,
    ADDR_COMMAND = 2'd2,
    ADDR_CONTROL = 2'd3
  } alr_addr_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Status bits 6 and 5 always read as one.
  localparam logic [7:0] STATUS_FIXED   = 8'h60;
  // A programmed reset keeps only the upper three command bits.
  localparam logic [7:0] CMD_KEEP_MASK  = 8'hE0;
  // Command bits 3:2 select the transmit interrupt with this code.
  localparam logic [1:0] TX_IRQ_ENABLE  = 2'b01;

  typedef struct packed {
    logic      mode;
    alr_addr_t reg_addr;
    logic [7:0] write_data;
  } alr_access_t;

  typedef struct packed {
    logic       irq;
    logic [7:0] read_data;
  } alr_result_t;

endpackage

/* sv/alr_regfile.sv */
// ----------------------------------------------------------------------------
// alr_regfile
// Register file of the serial interface: applies one access per strobe and
// returns the read byte and the interrupt level after the access.
// ----------------------------------------------------------------------------
module alr_regfile
  import alr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  alr_access_t acc,
  output alr_result_t res
);

  logic [7:0] rx_byte, rx_byte_next;
  logic       rx_full, rx_full_next;
  logic       tx_empty, tx_empty_next;
  logic       irq_flag, irq_flag_next;
  logic [7:0] command_reg, command_reg_next;
  logic [7:0] control_reg, control_reg_next;

  logic       do_check;
  logic       irq_hit;
  logic [7:0] rdata;

  always_comb begin
    rx_byte_next     = rx_byte;
    rx_full_next     = rx_full;
    tx_empty_next    = tx_empty;
    command_reg_next = command_reg;
    control_reg_next = control_reg;
    do_check         = 1'b0;
    rdata            = '0;
    if (acc.mode == MODE_WRITE) begin
      unique case (acc.reg_addr)
        ADDR_DATA: begin
          // Loopback: the transmitted byte lands in the receiver at once.
          tx_empty_next = 1'b1;
          rx_byte_next  = acc.write_data;
          rx_full_next  = 1'b1;
          do_check      = 1'b1;
        end
        ADDR_STATUS: begin
          command_reg_next = command_reg & CMD_KEEP_MASK;
          do_check         = 1'b1;
        end
        ADDR_COMMAND: begin
          command_reg_next = acc.write_data;
          do_check         = 1'b1;
        end
        default: begin
          control_reg_next = acc.write_data;
        end
      endcase
    end else begin
      unique case (acc.reg_addr)
        ADDR_DATA: begin
          rdata        = rx_byte;
          rx_full_next = 1'b0;
          do_check     = 1'b1;
        end
        ADDR_STATUS: begin
          rdata = STATUS_FIXED | {irq_flag, 2'b00, tx_empty, rx_full, 3'b000};
        end
        ADDR_COMMAND: begin
          rdata = command_reg;
        end
        default: begin
          rdata = control_reg;
        end
      endcase
    end

    irq_hit = (tx_empty_next && (command_reg_next[3:2] == TX_IRQ_ENABLE)) ||
              (rx_full_next && command_reg_next[1]);

    // Apart from reset, a status read is the only way the flag clears; the check only sets it.
    if ((acc.mode == MODE_READ) && (acc.reg_addr == ADDR_STATUS)) begin
      irq_flag_next = 1'b0;
    end else begin
      irq_flag_next = irq_flag | (do_check & irq_hit);
    end
  end

  assign res.read_data = rdata;
  assign res.irq       = irq_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_byte     <= '0;
      rx_full     <= 1'b0;
      tx_empty    <= 1'b1;
      irq_flag    <= 1'b0;
      command_reg <= '0;
      control_reg <= '0;
    end else if (en) begin
      rx_byte     <= rx_byte_next;
      rx_full     <= rx_full_next;
      tx_empty    <= tx_empty_next;
      irq_flag    <= irq_flag_next;
      command_reg <= command_reg_next;
      control_reg <= control_reg_next;
    end
  end

endmodule

/* sv/acia_loopback_registers.sv */
// ----------------------------------------------------------------------------
// acia_loopback_registers
// Path: an accepted request is held in the input register, then its result
// is loaded into the result register.
// Throughput: one request per cycle unless the output stalls; the register file
// updates as the request leaves the input register and the result is loaded.
// Reset: synchronous, active high; both stages empty, receiver empty,
// transmitter empty flag set, command, control and interrupt cleared.
// ----------------------------------------------------------------------------
module acia_loopback_registers
  import alr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] write_data
  input  logic [2:0]  s_tuser,   // [0] mode, [2:1] reg_addr
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_data, [8] irq, [15:9] zero
);

  logic        in_valid;
  alr_access_t in_acc;
  logic        in_adv;
  logic        out_valid;
  alr_result_t out_res;
  alr_result_t res;

  // The result register can take a new result when empty or being drained.
  assign in_adv   = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_acc.mode       <= s_tuser[0];
      in_acc.reg_addr   <= alr_addr_t'(s_tuser[2:1]);
      in_acc.write_data <= s_tdata;
    end
  end

  alr_regfile u_regfile (
    .clk (clk),
    .rst (rst),
    .en  (in_adv),
    .acc (in_acc),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.irq, out_res.read_data};

`ifndef SYNTH
  // A status read always leaves the interrupt line low.
  assert property (@(posedge clk) disable iff (rst)
    in_adv && (in_acc.mode == MODE_READ) && (in_acc.reg_addr == ADDR_STATUS)
    |=> (m_tdata[8] == 1'b0))
    else $error("irq not cleared by status read");

  // Write accesses return a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    in_adv && (in_acc.mode == MODE_WRITE) |=> (m_tdata[7:0] == 8'd0))
    else $error("write access returned nonzero data");

  // The input side stalls only when both stages are full and the output waits.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule

/* dv/acia_loopback_registers_test.sv */
// ----------------------------------------------------------------------------
// acia_loopback_registers_test
// Drives bus accesses into the loopback serial register block over its request
// stream; checks every result against a shadow model of the registers, or against
// table values for typed rows. A short table of directed accesses comes first,
// then random traffic, idle bursts on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module acia_loopback_registers_test;
  import alr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM  = 850;
  localparam int QUIET_TAIL  = 100;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 100000;
  localparam int NUM_ROWS    = 25;

  typedef struct packed {
    logic       mode;
    alr_addr_t  reg_addr;
    logic [7:0] write_data;
    logic       typed;
    logic [7:0] read_data;
    logic       irq;
  } access_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] write_data
  logic [2:0]  s_tuser;   // [0] mode, [2:1] reg_addr
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] read_data, [8] irq, [15:9] zero

  // Shadow copy of the register block.
  logic [7:0]  sh_rx_byte;
  logic        sh_rx_full;
  logic        sh_tx_empty;
  logic        sh_irq;
  logic [7:0]  sh_command;
  logic [7:0]  sh_control;

  alr_result_t pending_results[$];
  access_row_t access_table[NUM_ROWS];
  int          accepted_count = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;

  acia_loopback_registers u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic void raise_irq_if_armed();
    if ((sh_tx_empty && sh_command[3:2] == TX_IRQ_ENABLE) || (sh_rx_full && sh_command[1]))
      sh_irq = 1'b1;
  endfunction

  function automatic alr_result_t register_access(input alr_access_t acc);
    alr_result_t res;
    res.read_data = 8'h00;
    if (acc.mode == MODE_WRITE) begin
      case (acc.reg_addr)
        ADDR_DATA: begin
          // Loopback: the transmitted byte lands in the receiver at once.
          sh_tx_empty = 1'b1;
          sh_rx_byte  = acc.write_data;
          sh_rx_full  = 1'b1;
          raise_irq_if_armed();
        end
        ADDR_STATUS: begin
          sh_command = sh_command & CMD_KEEP_MASK;
          raise_irq_if_armed();
        end
        ADDR_COMMAND: begin
          sh_command = acc.write_data;
          raise_irq_if_armed();
        end
        default: sh_control = acc.write_data;
      endcase
    end else begin
      case (acc.reg_addr)
        ADDR_DATA: begin
          res.read_data = sh_rx_byte;
          sh_rx_full = 1'b0;
          raise_irq_if_armed();
        end
        ADDR_STATUS: begin
          res.read_data = STATUS_FIXED |
                          {sh_irq, 2'b00, sh_tx_empty, sh_rx_full, 3'b000};
          sh_irq = 1'b0;
        end
        ADDR_COMMAND: res.read_data = sh_command;
        default:      res.read_data = sh_control;
      endcase
    end
    res.irq = sh_irq;
    return res;
  endfunction

  function automatic alr_access_t random_access();
    alr_access_t acc;
    acc.mode       = 1'($urandom_range(0, 1));
    acc.reg_addr   = alr_addr_t'($urandom_range(0, 3));
    acc.write_data = 8'($urandom);
    // Half of the command writes arm one of the two interrupt sources.
    if (acc.mode == MODE_WRITE && acc.reg_addr == ADDR_COMMAND &&
        $urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 1) == 1) acc.write_data[3:2] = TX_IRQ_ENABLE;
      else acc.write_data[1] = 1'b1;
    end
    return acc;
  endfunction

  task automatic send_access(input alr_access_t acc, input logic typed,
                             input alr_result_t typed_res);
    alr_result_t predicted;
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= acc.write_data;
    s_tuser  <= {acc.reg_addr, acc.mode};
    do @(posedge clk); while (!s_tready);
    predicted = register_access(acc);
    pending_results.push_back(typed ? typed_res : predicted);
    accepted_count++;
  endtask

  // Receiver side: random stall bursts and one long hold-off that fills the block.
  initial begin
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alr_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: read_data %02h irq %0b",
               m_tdata[7:0], m_tdata[8]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.read_data) begin
          $error("read_data: expected %02h, actual %02h", want.read_data, m_tdata[7:0]);
          fail_count++;
        end
        if (m_tdata[8] !== want.irq) begin
          $error("irq: expected %0b, actual %0b", want.irq, m_tdata[8]);
          fail_count++;
        end
        if (m_tdata[15:9] !== 7'd0) begin
          $error("pad: expected 00, actual %02h", m_tdata[15:9]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("acia_loopback_registers test failed");
    $finish;
  end

  initial begin
    alr_access_t acc;
    alr_result_t typed_res;

    // mode, reg_addr, write_data, typed, read_data, irq
    access_table[0]  = '{MODE_READ,  ADDR_STATUS,  8'h00, 1'b1, 8'h70, 1'b0};
    access_table[1]  = '{MODE_READ,  ADDR_DATA,    8'hFF, 1'b1, 8'h00, 1'b0};
    access_table[2]  = '{MODE_READ,  ADDR_COMMAND, 8'h00, 1'b1, 8'h00, 1'b0};
    access_table[3]  = '{MODE_READ,  ADDR_CONTROL, 8'h00, 1'b1, 8'h00, 1'b0};
    access_table[4]  = '{MODE_WRITE, ADDR_CONTROL, 8'hFF, 1'b1, 8'h00, 1'b0};
    access_table[5]  = '{MODE_READ,  ADDR_CONTROL, 8'h00, 1'b1, 8'hFF, 1'b0};
    access_table[6]  = '{MODE_WRITE, ADDR_CONTROL, 8'h5A, 1'b1, 8'h00, 1'b0};
    access_table[7]  = '{MODE_WRITE, ADDR_DATA,    8'hFF, 1'b1, 8'h00, 1'b0};
    access_table[8]  = '{MODE_READ,  ADDR_STATUS,  8'h00, 1'b1, 8'h78, 1'b0};
    access_table[9]  = '{MODE_READ,  ADDR_DATA,    8'h00, 1'b1, 8'hFF, 1'b0};
    access_table[10] = '{MODE_WRITE, ADDR_COMMAND, 8'h04, 1'b1, 8'h00, 1'b1};
    access_table[11] = '{MODE_READ,  ADDR_STATUS,  8'h00, 1'b1, 8'hF0, 1'b0};
    access_table[12] = '{MODE_READ,  ADDR_COMMAND, 8'h00, 1'b1, 8'h04, 1'b0};
    // Overwrite an unread byte, then a programmed reset with all data bits set.
    access_table[13] = '{MODE_WRITE, ADDR_DATA,    8'h00, 1'b0, 8'h00, 1'b0};
    access_table[14] = '{MODE_WRITE, ADDR_DATA,    8'hC3, 1'b0, 8'h00, 1'b0};
    access_table[15] = '{MODE_WRITE, ADDR_STATUS,  8'hFF, 1'b0, 8'h00, 1'b0};
    access_table[16] = '{MODE_READ,  ADDR_STATUS,  8'h00, 1'b0, 8'h00, 1'b0};
    access_table[17] = '{MODE_WRITE, ADDR_COMMAND, 8'hFF, 1'b0, 8'h00, 1'b0};
    access_table[18] = '{MODE_WRITE, ADDR_STATUS,  8'h00, 1'b0, 8'h00, 1'b0};
    access_table[19] = '{MODE_READ,  ADDR_COMMAND, 8'h00, 1'b0, 8'h00, 1'b0};
    access_table[20] = '{MODE_READ,  ADDR_STATUS,  8'h00, 1'b0, 8'h00, 1'b0};
    access_table[21] = '{MODE_WRITE, ADDR_COMMAND, 8'h08, 1'b0, 8'h00, 1'b0};
    access_table[22] = '{MODE_WRITE, ADDR_COMMAND, 8'h02, 1'b0, 8'h00, 1'b0};
    // Data read twice: the second one clears an already clear receive flag.
    access_table[23] = '{MODE_READ,  ADDR_DATA,    8'h00, 1'b0, 8'h00, 1'b0};
    access_table[24] = '{MODE_READ,  ADDR_DATA,    8'h00, 1'b0, 8'h00, 1'b0};

    sh_rx_byte  = 8'h00;
    sh_rx_full  = 1'b0;
    sh_tx_empty = 1'b1;
    sh_irq      = 1'b0;
    sh_command  = 8'h00;
    sh_control  = 8'h00;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= 3'b000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      acc.mode            = access_table[i].mode;
      acc.reg_addr        = access_table[i].reg_addr;
      acc.write_data      = access_table[i].write_data;
      typed_res.read_data = access_table[i].read_data;
      typed_res.irq       = access_table[i].irq;
      send_access(acc, access_table[i].typed, typed_res);
    end

    typed_res = '0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i >= NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      send_access(random_access(), 1'b0, typed_res);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("acia_loopback_registers test passed");
    end else begin
      $display("acia_loopback_registers test failed");
    end
    $finish;
  end

endmodule
